FILE: hdl/rnb_pkg.sv
// rms norm backward: shared types, field widths and codes
// used by the interfaces, front, back, job queue and top; depends on nothing
package rnb_pkg;

  localparam int DATA_W   = 16;   // x and dy, signed Q4.11
  localparam int LEN_W    = 7;    // row length and element count
  localparam int EPS_W    = 22;   // epsilon, Q.22
  localparam int CFG_W    = 22;   // widest configuration register
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W    = 36;   // square sum, Q.22
  localparam int MS_W     = 37;   // mean square plus epsilon
  localparam int SQ_W     = 48;   // sqrt radicand
  localparam int RMS_W    = 24;   // rms, Q.16
  localparam int DIV_NW   = 41;   // divider numerator width
  localparam int DIV_DW   = 24;   // divider denominator width
  localparam int VAL_W    = 48;   // result value, Q31.16
  localparam int IDX_W    = 6;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
  localparam logic [EPS_W-1:0] EPS_RESET = 22'd4;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_IGRAD = 1'b0,
    KIND_WGRAD = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 1'b0,
    CFG_EPSILON    = 1'b1
  } cfg_reg_t;

  // one unit of work handed from front to back
  typedef struct packed {
    logic             is_read;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [SUM_W-1:0] sum;
    logic [EPS_W-1:0] eps;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MEAN,
    BK_SQRT,
    BK_ROW_RD,
    BK_ROW_DATA,
    BK_ROW_DIV,
    BK_ROW_OUT,
    BK_WG_RD,
    BK_WG_OUT
  } back_state_t;

endpackage

FILE: hdl/rnb_if.sv
// rms norm backward: input and result channel interfaces
// depends on rnb_pkg for field widths
interface rnb_in_if import rnb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] dy_value;

  modport source (output valid, cmd, x_value, dy_value, input ready);
  modport sink   (input valid, cmd, x_value, dy_value, output ready);
endinterface

interface rnb_out_if import rnb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, kind, index, value, last, input ready);
  modport sink   (input valid, kind, index, value, last, output ready);
endinterface

FILE: hdl/rnb_ram.sv
// rms norm backward: generic single-write, single-read ram, registered read
// no dependencies
module rnb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/rnb_div.sv
// rms norm backward: unsigned restoring divider, one quotient bit per cycle
// no dependencies
module rnb_div #(
  parameter int NW = 41,
  parameter int DW = 24,
  localparam int CW = $clog2(NW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   rem_sh;
  logic          ge;

  // one shift-subtract step per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    if (start) begin
      cnt_nxt = CW'(NW);
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[NW-2:0], ge};
      rem_nxt = ge ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = cnt_r != '0;
  assign quo  = quo_r;

endmodule

FILE: hdl/rnb_jobq.sv
// rms norm backward: two-entry job queue between front and back
// depends on rnb_pkg for job_t
module rnb_jobq import rnb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output job_t job_out,
  output logic empty
);

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= job_in;
    end
  end

  assign job_out = ent_r[rp_r];
  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;

endmodule

FILE: hdl/rnb_front.sv
// rms norm backward: front end, takes beats, stores row elements,
// sums squares and queues row and read jobs; depends on rnb_pkg, rnb_if
module rnb_front import rnb_pkg::*; #(
  parameter int MAX_HIDDEN = 64,
  localparam int AW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rnb_in_if.sink                 in_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic                   row_we,
  output logic [AW:0]            row_waddr,
  output logic [2*DATA_W-1:0]    row_wdata,
  output logic                   q_push,
  output job_t                   q_job,
  input  logic                   q_full,
  input  logic                   row_done
);

  logic [LEN_W-1:0] row_length_r, row_length_nxt;
  logic [EPS_W-1:0] eps_r, eps_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       rows_out_r, rows_out_nxt;

  logic [LEN_W-1:0]    eff_len;
  logic [DATA_W-1:0]   mag_x;
  logic [2*DATA_W-1:0] sq;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_sat;
  logic [LEN_W-1:0]    count_inc;
  logic                accept, is_read, load, row_end, row_push;

  // clamp of the row length register
  always_comb begin
    if (row_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (row_length_r > LEN_W'(MAX_HIDDEN)) begin
      eff_len = LEN_W'(MAX_HIDDEN);
    end else begin
      eff_len = row_length_r;
    end
  end

  // square of the activation, saturating sum
  always_comb begin
    mag_x   = in_ch.x_value[DATA_W-1] ? DATA_W'(~in_ch.x_value + 1'b1) : in_ch.x_value;
    sq      = mag_x * mag_x;
    sum_add = {1'b0, sum_r} + (SUM_W+1)'(sq);
    sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  end

  // beat handling; any beat stalls while the job queue is full or both row banks belong to the back
  assign in_ch.ready = !q_full && (rows_out_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_read     = in_ch.cmd == CMD_READ;
  assign load        = accept && !is_read;
  assign count_inc   = count_r + 1'b1;
  assign row_end     = count_inc >= eff_len;
  assign row_push    = load && row_end;

  assign row_we    = load;
  assign row_waddr = {bank_r, count_r[AW-1:0]};
  assign row_wdata = {in_ch.x_value, in_ch.dy_value};

  assign q_push        = (accept && is_read) || row_push;
  assign q_job.is_read = is_read;
  assign q_job.bank    = bank_r;
  assign q_job.len     = eff_len;
  assign q_job.sum     = sum_sat;
  assign q_job.eps     = eps_r;

  // next state
  always_comb begin
    row_length_nxt = row_length_r;
    eps_nxt        = eps_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    bank_nxt       = bank_r;
    rows_out_nxt   = rows_out_r + {1'b0, row_push} - {1'b0, row_done};
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH: row_length_nxt = cfg_data[LEN_W-1:0];
        CFG_EPSILON:    eps_nxt        = cfg_data[EPS_W-1:0];
        default:        ;
      endcase
    end
    if (load) begin
      if (row_end) begin
        sum_nxt   = '0;
        count_nxt = '0;
        bank_nxt  = ~bank_r;
      end else begin
        sum_nxt   = sum_sat;
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= LEN_RESET;
      eps_r        <= EPS_RESET;
      sum_r        <= '0;
      count_r      <= '0;
      bank_r       <= 1'b0;
      rows_out_r   <= 2'd0;
    end else begin
      row_length_r <= row_length_nxt;
      eps_r        <= eps_nxt;
      sum_r        <= sum_nxt;
      count_r      <= count_nxt;
      bank_r       <= bank_nxt;
      rows_out_r   <= rows_out_nxt;
    end
  end

endmodule

FILE: hdl/rnb_back.sv
// rms norm backward: back end, mean, square root, per-column gradients,
// weight accumulators and result register; depends on rnb_pkg, rnb_if,
// rnb_ram, rnb_div
module rnb_back import rnb_pkg::*; #(
  parameter int MAX_HIDDEN = 64,
  localparam int AW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  job_t                q_job,
  output logic                q_pop,
  output logic                row_re,
  output logic [AW:0]         row_raddr,
  input  logic [2*DATA_W-1:0] row_rdata,
  output logic                row_done,
  rnb_out_if.source           out_ch
);

  back_state_t      state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [LEN_W-1:0] h_r, h_nxt;
  logic [RMS_W-1:0] rms_r, rms_nxt;
  logic [SQ_W-1:0]  sq_v_r, sq_v_nxt;
  logic [25:0]      sq_rem_r, sq_rem_nxt;
  logic [RMS_W-1:0] sq_res_r, sq_res_nxt;
  logic [4:0]       sq_i_r, sq_i_nxt;
  logic             neg_g_r, neg_g_nxt, neg_w_r, neg_w_nxt;
  logic             zero_g_r, zero_g_nxt, zero_w_r, zero_w_nxt;
  logic signed [VAL_W-1:0] acc_r, acc_nxt;
  logic [MAX_HIDDEN-1:0]   acc_vld_r, acc_vld_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]        out_index_r, out_index_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;

  // accumulator memory
  logic             acc_we, acc_re;
  logic [VAL_W-1:0] acc_wdata, acc_rdata;

  // dividers: a does the mean and the weight term, b the input gradient
  logic              div_a_start, div_b_start, div_a_busy, div_b_busy;
  logic [DIV_NW-1:0] div_a_num, div_b_num, div_a_quo, div_b_quo;
  logic [DIV_DW-1:0] div_a_den;

  // element datapath
  logic signed [DATA_W-1:0] x_s, dy_s;
  logic [DATA_W-1:0]        mag_x, mag_dy;
  logic [2*DATA_W-1:0]      prod;
  logic [DIV_NW-1:0]        num_w, num_g;
  logic [MS_W-1:0]          ms;
  logic [25:0]              rem_sh, trial;
  logic                     sq_ge;
  logic signed [VAL_W-1:0]  g_val, w_val, q_g, q_w;
  logic signed [VAL_W:0]    acc_sum;
  logic signed [VAL_W-1:0]  acc_sat;
  logic                     out_free, is_last, h_vld;

  rnb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_HIDDEN)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (h_r[AW-1:0]),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (h_r[AW-1:0]),
    .rdata (acc_rdata)
  );

  rnb_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_a_start),
    .num   (div_a_num),
    .den   (div_a_den),
    .busy  (div_a_busy),
    .quo   (div_a_quo)
  );

  rnb_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_b_start),
    .num   (div_b_num),
    .den   (rms_r),
    .busy  (div_b_busy),
    .quo   (div_b_quo)
  );

  // element operands from the row store
  always_comb begin
    x_s    = row_rdata[2*DATA_W-1:DATA_W];
    dy_s   = row_rdata[DATA_W-1:0];
    mag_x  = x_s[DATA_W-1] ? DATA_W'(~x_s + 1'b1) : x_s;
    mag_dy = dy_s[DATA_W-1] ? DATA_W'(~dy_s + 1'b1) : dy_s;
    prod   = mag_dy * mag_x;
    num_w  = {prod[2*DATA_W-2:0], 10'b0};
    num_g  = DIV_NW'({mag_dy, 21'b0});
  end

  // divider operand selection
  assign div_a_num = (state_r == BK_IDLE) ? DIV_NW'(q_job.sum) : num_w;
  assign div_a_den = (state_r == BK_IDLE) ? DIV_DW'(q_job.len) : rms_r;
  assign div_b_num = num_g;

  // mean square plus epsilon, one square root step
  always_comb begin
    ms     = MS_W'(div_a_quo[SUM_W-1:0]) + MS_W'(job_r.eps);
    rem_sh = {sq_rem_r[23:0], sq_v_r[SQ_W-1:SQ_W-2]};
    trial  = {sq_res_r, 2'b01};
    sq_ge  = rem_sh >= trial;
  end

  // signed, saturated results of the two quotients
  always_comb begin
    q_g = VAL_W'(div_b_quo);
    q_w = VAL_W'(div_a_quo);
    if (zero_g_r) begin
      g_val = '0;
    end else if (rms_r == '0) begin
      g_val = neg_g_r ? VAL_MIN : VAL_MAX;
    end else begin
      g_val = neg_g_r ? -q_g : q_g;
    end
    if (zero_w_r) begin
      w_val = '0;
    end else if (rms_r == '0) begin
      w_val = neg_w_r ? VAL_MIN : VAL_MAX;
    end else begin
      w_val = neg_w_r ? -q_w : q_w;
    end
    acc_sum = {acc_r[VAL_W-1], acc_r} + {w_val[VAL_W-1], w_val};
    if (acc_sum[VAL_W] != acc_sum[VAL_W-1]) begin
      acc_sat = acc_sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      acc_sat = acc_sum[VAL_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = (h_r + 1'b1) == job_r.len;
  assign h_vld    = acc_vld_r[h_r[AW-1:0]];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    h_nxt         = h_r;
    rms_nxt       = rms_r;
    sq_v_nxt      = sq_v_r;
    sq_rem_nxt    = sq_rem_r;
    sq_res_nxt    = sq_res_r;
    sq_i_nxt      = sq_i_r;
    neg_g_nxt     = neg_g_r;
    neg_w_nxt     = neg_w_r;
    zero_g_nxt    = zero_g_r;
    zero_w_nxt    = zero_w_r;
    acc_nxt       = acc_r;
    acc_vld_nxt   = acc_vld_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    row_re        = 1'b0;
    row_raddr     = {job_r.bank, h_r[AW-1:0]};
    row_done      = 1'b0;
    acc_we        = 1'b0;
    acc_re        = 1'b0;
    acc_wdata     = acc_sat;
    div_a_start   = 1'b0;
    div_b_start   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          h_nxt   = '0;
          if (q_job.is_read) begin
            state_nxt = BK_WG_RD;
          end else begin
            div_a_start = 1'b1;
            state_nxt   = BK_MEAN;
          end
        end
      end
      BK_MEAN: begin
        if (!div_a_busy) begin
          sq_v_nxt   = SQ_W'({ms, 10'b0});
          sq_rem_nxt = '0;
          sq_res_nxt = '0;
          sq_i_nxt   = 5'd23;
          state_nxt  = BK_SQRT;
        end
      end
      BK_SQRT: begin
        sq_v_nxt   = {sq_v_r[SQ_W-3:0], 2'b00};
        sq_rem_nxt = sq_ge ? rem_sh - trial : rem_sh;
        sq_res_nxt = {sq_res_r[RMS_W-2:0], sq_ge};
        sq_i_nxt   = sq_i_r - 1'b1;
        if (sq_i_r == '0) begin
          rms_nxt   = {sq_res_r[RMS_W-2:0], sq_ge};
          state_nxt = BK_ROW_RD;
        end
      end
      BK_ROW_RD: begin
        row_re    = 1'b1;
        acc_re    = 1'b1;
        state_nxt = BK_ROW_DATA;
      end
      BK_ROW_DATA: begin
        div_a_start = 1'b1;
        div_b_start = 1'b1;
        neg_g_nxt   = dy_s[DATA_W-1];
        zero_g_nxt  = dy_s == '0;
        neg_w_nxt   = dy_s[DATA_W-1] ^ x_s[DATA_W-1];
        zero_w_nxt  = (dy_s == '0) || (x_s == '0);
        acc_nxt     = h_vld ? acc_rdata : '0;
        state_nxt   = BK_ROW_DIV;
      end
      BK_ROW_DIV: begin
        if (!div_a_busy && !div_b_busy) begin
          state_nxt = BK_ROW_OUT;
        end
      end
      BK_ROW_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_IGRAD;
          out_index_nxt = h_r[IDX_W-1:0];
          out_value_nxt = g_val;
          out_last_nxt  = is_last;
          acc_we        = 1'b1;
          acc_vld_nxt[h_r[AW-1:0]] = 1'b1;
          h_nxt         = h_r + 1'b1;
          if (is_last) begin
            row_done  = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_ROW_RD;
          end
        end
      end
      BK_WG_RD: begin
        acc_re    = 1'b1;
        state_nxt = BK_WG_OUT;
      end
      BK_WG_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_WGRAD;
          out_index_nxt = h_r[IDX_W-1:0];
          out_value_nxt = h_vld ? acc_rdata : '0;
          out_last_nxt  = is_last;
          h_nxt         = h_r + 1'b1;
          if (is_last) begin
            acc_vld_nxt = '0;
            state_nxt   = BK_IDLE;
          end else begin
            state_nxt = BK_WG_RD;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      acc_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_vld_r   <= acc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    h_r         <= h_nxt;
    rms_r       <= rms_nxt;
    sq_v_r      <= sq_v_nxt;
    sq_rem_r    <= sq_rem_nxt;
    sq_res_r    <= sq_res_nxt;
    sq_i_r      <= sq_i_nxt;
    neg_g_r     <= neg_g_nxt;
    neg_w_r     <= neg_w_nxt;
    zero_g_r    <= zero_g_nxt;
    zero_w_r    <= zero_w_nxt;
    acc_r       <= acc_nxt;
    out_kind_r  <= out_kind_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.index = out_index_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

endmodule

FILE: hdl/rms_norm_backward.sv
// Loads: one beat per cycle, rows kept in two banks; beats stall while the job queue
// is full or two finished rows wait for the back end.
// Row end: the mean divide and the square root run after the last load, then for each
// column the row and accumulator reads, the divider pair and the input gradient beat.
// Read command: for each column an accumulator read, then the weight gradient beat.
// Reset (rst_n low, synchronous) clears control state; accumulators read as zero.
module rms_norm_backward import rnb_pkg::*; #(
  parameter int MAX_HIDDEN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rnb_in_if.sink               in_ch,
  rnb_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;

  logic                row_we, row_re, row_done;
  logic [AW:0]         row_waddr, row_raddr;
  logic [2*DATA_W-1:0] row_wdata, row_rdata;
  logic                q_push, q_full, q_pop, q_empty;
  job_t                q_job_in, q_job_out;

  rnb_front #(.MAX_HIDDEN(MAX_HIDDEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_we    (row_we),
    .row_waddr (row_waddr),
    .row_wdata (row_wdata),
    .q_push    (q_push),
    .q_job     (q_job_in),
    .q_full    (q_full),
    .row_done  (row_done)
  );

  // two banks of row elements, x and dy side by side
  rnb_ram #(.WIDTH(2*DATA_W), .DEPTH(2 << AW)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  rnb_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_job_in),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_job_out),
    .empty   (q_empty)
  );

  rnb_back #(.MAX_HIDDEN(MAX_HIDDEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job_out),
    .q_pop     (q_pop),
    .row_re    (row_re),
    .row_raddr (row_raddr),
    .row_rdata (row_rdata),
    .row_done  (row_done),
    .out_ch    (out_ch)
  );

  // job queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("job popped from empty queue");

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_ch.valid) else $error("result valid after reset");

endmodule
